// ===== rtl/core/acst_pkg.sv =====
// ----------------------------------------------------------------------------
// acst_pkg
// Shared types and constants of the affine composite segment tree.
// ----------------------------------------------------------------------------
package acst_pkg;

   localparam int unsigned DefaultLeaves = 1024;
   localparam int unsigned IdxW  = 10;
   localparam int unsigned DataW = 64;

   localparam logic OP_SET   = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef struct packed {
      logic [DataW-1:0] m;
      logic [DataW-1:0] a;
   } amap_type;

   localparam amap_type IDENT = '{m: 64'd1, a: 64'd0};

   typedef struct packed {
      logic              op;
      logic [IdxW-1:0]   leaf_index;
      logic [DataW-1:0]  coef_mult;
      logic [DataW-1:0]  coef_add;
      logic [IdxW-1:0]   range_lo;
      logic [IdxW-1:0]   range_hi;
   } req_type;

   typedef struct packed {
      logic [DataW-1:0] result_mult;
      logic [DataW-1:0] result_add;
   } rsp_type;

endpackage

// ===== rtl/core/acst_if.sv =====
// ----------------------------------------------------------------------------
// acst_if
// Valid/ready channel that carries one item of a given payload type.
// ----------------------------------------------------------------------------
interface acst_if #(parameter type payload_type = logic) (input logic clock);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/affine_composite_segment_tree_top.sv =====
// ----------------------------------------------------------------------------
// affine_composite_segment_tree_top
// Segment tree of affine maps with point set and range composite query.
// ----------------------------------------------------------------------------
//  Channel  Direction  Payload
//  req      in         op, leaf_index, coef_mult, coef_add, range_lo, range_hi
//  rsp      out        result_mult, result_add
//
// A set does, per tree level, two memory reads and one compose of six
// 32x32 partial products in the shared multiply unit.
// A query takes up to two composes per level plus a final one.
// After reset a clearing pass writes all 2*span node entries, one per cycle,
// before the first item is taken. The block takes one item at a time.
module affine_composite_segment_tree_top #(
   parameter int unsigned LEAVES = acst_pkg::DefaultLeaves
) (
   input  logic clock,
   input  logic reset,
   acst_if.sink   req,
   acst_if.source rsp
);
   import acst_pkg::*;

   acst_seq #(.LEAVES(LEAVES)) u_seq (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp)
   );
endmodule

// ===== rtl/core/acst_compose.sv =====
// ----------------------------------------------------------------------------
// acst_compose
// Shared unit that composes two affine maps with two 64x64 low products
// built from 32x32 partial products, one per cycle.
// ----------------------------------------------------------------------------
module acst_compose (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  acst_pkg::amap_type  x,
   input  acst_pkg::amap_type  y,
   output logic                done,
   output acst_pkg::amap_type  z
);
   import acst_pkg::*;

   // Two products (x.m*y.m and x.a*y.m), three partial products each.
   logic [2:0]        step_ff, step_in;
   logic              run_ff, run_in;
   amap_type          x_ff, x_in, y_ff, y_in;
   logic [DataW-1:0]  pm_ff, pm_in, pa_ff, pa_in;
   logic [31:0]       op_a, op_b;
   logic [63:0]       prod_ff;
   logic [DataW-1:0]  acc;

   // Pick the operand halves for this step.
   always_comb begin
      op_a = '0;
      op_b = '0;
      case (step_ff)
         3'd0: begin op_a = x_ff.m[31:0];  op_b = y_ff.m[31:0];  end
         3'd1: begin op_a = x_ff.m[63:32]; op_b = y_ff.m[31:0];  end
         3'd2: begin op_a = x_ff.m[31:0];  op_b = y_ff.m[63:32]; end
         3'd3: begin op_a = x_ff.a[31:0];  op_b = y_ff.m[31:0];  end
         3'd4: begin op_a = x_ff.a[63:32]; op_b = y_ff.m[31:0];  end
         3'd5: begin op_a = x_ff.a[31:0];  op_b = y_ff.m[63:32]; end
         default: begin op_a = '0; op_b = '0; end
      endcase
   end

   // The partial product of each step is registered and folded in at the following step.
   always_comb begin
      step_in = step_ff;
      run_in  = run_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      pm_in   = pm_ff;
      pa_in   = pa_ff;
      acc     = '0;
      done    = 1'b0;
      if (start) begin
         run_in  = 1'b1;
         step_in = '0;
         x_in    = x;
         y_in    = y;
      end else if (run_ff) begin
         step_in = step_ff + 3'd1;
         case (step_ff)
            3'd1: pm_in = prod_ff;
            3'd2: pm_in = pm_ff + {prod_ff[31:0], 32'd0};
            3'd3: pm_in = pm_ff + {prod_ff[31:0], 32'd0};
            3'd4: pa_in = prod_ff + y_ff.a;
            3'd5: pa_in = pa_ff + {prod_ff[31:0], 32'd0};
            3'd6: begin
               acc    = pa_ff + {prod_ff[31:0], 32'd0};
               pa_in  = acc;
               run_in = 1'b0;
               done   = 1'b1;
            end
            default: ;
         endcase
      end
   end

   assign z = '{m: pm_ff, a: pa_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         step_ff <= '0;
      end else begin
         run_ff  <= run_in;
         step_ff <= step_in;
      end
      x_ff    <= x_in;
      y_ff    <= y_in;
      pm_ff   <= pm_in;
      pa_ff   <= pa_in;
      prod_ff <= op_a * op_b;
   end
endmodule

// ===== rtl/core/acst_seq.sv =====
// ----------------------------------------------------------------------------
// acst_seq
// Sequencer: walks the tree for set and query items, holds the node memory
// and drives the shared compose unit.
// ----------------------------------------------------------------------------
module acst_seq #(
   parameter int unsigned LEAVES = acst_pkg::DefaultLeaves
) (
   input  logic               clock,
   input  logic               reset,
   acst_if.sink               req,
   acst_if.source             rsp
);
   import acst_pkg::*;

   localparam int unsigned LvW  = (LEAVES <= 2) ? 1 : $clog2(LEAVES);
   localparam int unsigned Span = 1 << LvW;
   localparam int unsigned NW   = LvW + 1;
   localparam int unsigned Depth = 2 * Span;

   localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_SREAD = 4'd2,
      S_SRD2 = 4'd3, S_SCOMP = 4'd4, S_QTEST = 4'd5, S_QRD = 4'd6,
      S_QCOMP = 4'd7, S_QFIN = 4'd8, S_OUT = 4'd9, S_SWAIT = 4'd10,
      S_QSTEP = 4'd11;

   // Node memory, one map per node; node 0 unused.
   amap_type        mem [Depth];
   amap_type        rd_ff;
   logic [NW-1:0]   raddr, waddr;
   logic            we;
   amap_type        wdata;
   logic [NW-1:0]   clr_ff, clr_in;

   logic [3:0]      state_ff, state_in;
   logic [NW:0]     l_ff, l_in, r_ff, r_in, p_ff, p_in;
   amap_type        left_ff, left_in, right_ff, right_in, sib_ff, sib_in;
   logic            side_ff, side_in;   // 0 = left accumulator pending
   logic            cstart;
   amap_type        cx, cy, cz;
   logic            cdone;
   rsp_type         out_ff, out_in;
   logic [NW:0]     hi_c;

   acst_compose u_comp (
      .clock(clock), .reset(reset), .start(cstart), .x(cx), .y(cy),
      .done(cdone), .z(cz)
   );

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rd_ff <= mem[raddr];
   end

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = (state_ff == S_OUT);
   assign rsp.payload = out_ff;

   // The upper end of a query is clamped to the last leaf of the tree.
   always_comb begin
      if (32'(req.payload.range_hi) >= Span) hi_c = (NW+1)'(Span - 1);
      else hi_c = (NW+1)'(req.payload.range_hi);
   end

   // Main sequencer.
   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      l_in = l_ff; r_in = r_ff; p_in = p_ff;
      left_in = left_ff; right_in = right_ff; sib_in = sib_ff;
      side_in = side_ff;
      out_in = out_ff;
      raddr = '0; waddr = '0; we = 1'b0; wdata = IDENT;
      cstart = 1'b0; cx = IDENT; cy = IDENT;
      case (state_ff)
         S_CLEAR: begin
            we = 1'b1; waddr = clr_ff; wdata = IDENT;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == NW'(Depth - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            left_in = IDENT; right_in = IDENT;
            if (req.valid) begin
               if (req.payload.op == OP_SET) begin
                  if (32'(req.payload.leaf_index) < Span) begin
                     p_in = (NW+1)'(req.payload.leaf_index) + (NW+1)'(Span);
                     we = 1'b1;
                     waddr = NW'((NW+1)'(req.payload.leaf_index) + (NW+1)'(Span));
                     wdata = '{m: req.payload.coef_mult, a: req.payload.coef_add};
                     state_in = S_SREAD;
                  end
               end else if (32'(req.payload.range_lo) <= 32'(hi_c)) begin
                  l_in = (NW+1)'(req.payload.range_lo) + (NW+1)'(Span);
                  r_in = hi_c + (NW+1)'(Span) + 1'b1;
                  state_in = S_QTEST;
               end else begin
                  out_in = '{result_mult: IDENT.m, result_add: IDENT.a};
                  state_in = S_OUT;
               end
            end
         end
         // Set: read both children of the parent, compose, write parent.
         S_SREAD: begin
            if (p_ff <= (NW+1)'(1)) state_in = S_IDLE;
            else begin
               raddr = NW'({p_ff[NW:1], 1'b0});
               state_in = S_SRD2;
            end
         end
         S_SRD2: begin
            sib_in = rd_ff;
            raddr = NW'({p_ff[NW:1], 1'b1});
            state_in = S_SCOMP;
         end
         S_SCOMP: begin
            cstart = 1'b1; cx = sib_ff; cy = rd_ff;
            state_in = S_SWAIT;
         end
         S_SWAIT: begin
            if (cdone) begin
               we = 1'b1; waddr = NW'(p_ff >> 1); wdata = cz;
               p_in = p_ff >> 1;
               state_in = S_SREAD;
            end
         end
         // Query: handle the left boundary then the right one per level.
         S_QTEST: begin
            if (l_ff >= r_ff) state_in = S_QFIN;
            else if (l_ff[0]) begin
               side_in = 1'b0; raddr = NW'(l_ff); state_in = S_QRD;
            end else if (r_ff[0]) begin
               side_in = 1'b1; raddr = NW'(r_ff - 1'b1); state_in = S_QRD;
            end else state_in = S_QSTEP;
         end
         S_QRD: begin
            cstart = 1'b1;
            if (!side_ff) begin cx = left_ff; cy = rd_ff; end
            else begin cx = rd_ff; cy = right_ff; end
            state_in = S_QCOMP;
         end
         S_QCOMP: begin
            if (cdone) begin
               if (!side_ff) begin
                  left_in = cz; l_in = l_ff + 1'b1;
                  if (r_ff[0]) begin
                     side_in = 1'b1; raddr = NW'(r_ff - 1'b1); state_in = S_QRD;
                  end else state_in = S_QSTEP;
               end else begin
                  right_in = cz; r_in = r_ff - 1'b1;
                  state_in = S_QSTEP;
               end
            end
         end
         S_QSTEP: begin
            l_in = l_ff >> 1; r_in = r_ff >> 1;
            state_in = S_QTEST;
         end
         S_QFIN: begin
            if (!cdone && !side_ff) begin
               cstart = 1'b1; cx = left_ff; cy = right_ff;
               side_in = 1'b1;
            end else if (cdone) begin
               out_in = '{result_mult: cz.m, result_add: cz.a};
               state_in = S_OUT;
            end
         end
         S_OUT: if (rsp.ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
      if (state_ff == S_QTEST && l_ff >= r_ff) side_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         side_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         side_ff  <= side_in;
      end
      l_ff <= l_in; r_ff <= r_in; p_ff <= p_in;
      left_ff <= left_in; right_ff <= right_in; sib_ff <= sib_in;
      out_ff <= out_in;
   end
endmodule

// ===== rtl/core/acst_checker.sv =====
// ----------------------------------------------------------------------------
// acst_checker
// Port-level checks of the tree's handshake behavior.
// ----------------------------------------------------------------------------
module acst_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input acst_pkg::rsp_type rsp_payload
);
   import acst_pkg::*;

   // The block never takes an item while a result is offered.
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready while result pending");

   // A result that has been taken is not offered a second time.
   a_once: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> !rsp_valid) else $error("result repeated");

   // A stalled result holds.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result dropped");
endmodule

bind affine_composite_segment_tree_top acst_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_payload(rsp.payload)
);
